[rtl/touch_key_charge_time_sensor_unit_defines.svh]
// Assertion helpers for the checker file.
`ifndef TOUCH_KEY_CHARGE_TIME_SENSOR_UNIT_DEFINES_SVH
`define TOUCH_KEY_CHARGE_TIME_SENSOR_UNIT_DEFINES_SVH

// Plain property, sampled on clk, off while in reset.
`define TKCTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off while in reset.
`define TKCTS_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/tkcts_pkg.sv]
package tkcts_pkg;

    localparam int THR_W     = 9;
    localparam int HOLD_W    = 16;
    localparam int LIMIT_W   = 3;
    localparam int HIST_W    = 8;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THR    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_THR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT    = CFG_IDX_W'(3);

    localparam logic [THR_W-1:0]   CHARGE_THR_RST    = '0;
    localparam logic [THR_W-1:0]   DISCHARGE_THR_RST = '0;
    localparam logic [HOLD_W-1:0]  HOLDOFF_MS_RST    = HOLD_W'(43);
    localparam logic [LIMIT_W-1:0] VOTE_LIMIT_RST    = LIMIT_W'(3);

    typedef enum logic [1:0] {
        VERDICT_RELEASED  = 2'd0,
        VERDICT_TOUCHED   = 2'd1,
        VERDICT_UNDECIDED = 2'd2
    } verdict_t;

    typedef struct packed {
        logic sense_level;
        logic ms_tick;
    } in_t;

    typedef struct packed {
        logic             drive_level;
        logic [1:0]       key_index;
        logic             key_done;
        logic [1:0]       verdict;
        logic [HIST_W-1:0] key_history;
    } out_t;

    // history update request to the key store
    typedef struct packed {
        logic     en;
        verdict_t verdict;
    } key_update_t;

endpackage

[rtl/touch_key_charge_time_sensor_unit.sv]
// An accepted sample's result is written to the output register in the cycle after it is accepted.
// Throughput: one sample per cycle while not stalled; all counter and verdict logic sits between
// the sample port and the output register.
// Input stalls only while the output register holds a result that is stalled.
// Reset (rst_n, async low) clears counters, histories, touch stamps and the
// ms timer, and loads the registers with 0, 0, 43, 3.
module touch_key_charge_time_sensor_unit
    import tkcts_pkg::*;
#(
    parameter int NUM_KEYS    = 4,
    parameter int ROUNDS      = 5,
    parameter int DELAY_LIMIT = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int DW    = $clog2(DELAY_LIMIT + 1);
    localparam int CW    = (DW > THR_W) ? DW : THR_W;
    localparam int RW    = $clog2(ROUNDS + 1);

    localparam logic [DW-1:0]    LIMIT    = DW'(DELAY_LIMIT);
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    logic [THR_W-1:0]   charge_thr_reg;
    logic [THR_W-1:0]   discharge_thr_reg;
    logic [HOLD_W-1:0]  holdoff_reg;
    logic [LIMIT_W-1:0] vote_limit_reg;

    logic              discharging_reg, discharging_next;
    logic [DW-1:0]     delay_count_reg, delay_count_next;
    logic [DW-1:0]     charge_delay_reg, charge_delay_next;
    logic [RW-1:0]     round_count_reg, round_count_next;
    logic [RW-1:0]     vote_count_reg, vote_count_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TIME_W-1:0] ms_time_reg, ms_time_next;

    logic              out_valid_reg;
    out_t              out_data_reg;

    logic              accept;
    logic [DW-1:0]     count_inc;
    logic [DW-1:0]     dis_delay;
    logic              ended;
    logic              vote;
    logic [RW-1:0]     votes;
    logic [RW-1:0]     rounds;
    logic              done;
    verdict_t          verdict;
    key_update_t       update;
    logic [HIST_W-1:0] history;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign count_inc = delay_count_reg + DW'(1);

    always_comb
    begin
        discharging_next  = discharging_reg;
        delay_count_next  = delay_count_reg;
        charge_delay_next = charge_delay_reg;
        round_count_next  = round_count_reg;
        vote_count_next   = vote_count_reg;
        key_next          = key_reg;
        ms_time_next      = ms_time_reg;
        dis_delay         = '0;
        ended             = 1'b0;
        vote              = 1'b0;
        votes             = vote_count_reg;
        rounds            = round_count_reg;
        done              = 1'b0;
        verdict           = VERDICT_RELEASED;

        if (accept)
        begin
            if (in_data.ms_tick)
            begin
                ms_time_next = ms_time_reg + TIME_W'(1);
            end

            if (!discharging_reg)
            begin
                if (in_data.sense_level)
                begin
                    charge_delay_next = delay_count_reg;
                    delay_count_next  = '0;
                    discharging_next  = 1'b1;
                end
                else if (count_inc >= LIMIT)
                begin
                    charge_delay_next = LIMIT;
                    delay_count_next  = '0;
                    discharging_next  = 1'b1;
                end
                else
                begin
                    delay_count_next = count_inc;
                end
            end
            else
            begin
                if (!in_data.sense_level)
                begin
                    dis_delay = delay_count_reg;
                    ended     = 1'b1;
                end
                else if (count_inc >= LIMIT)
                begin
                    dis_delay = LIMIT;
                    ended     = 1'b1;
                end
                else
                begin
                    delay_count_next = count_inc;
                end
            end

            if (ended)
            begin
                delay_count_next = '0;
                discharging_next = 1'b0;
                // timed-out phases never vote
                vote = (CW'(charge_delay_reg) > CW'(charge_thr_reg))
                    && (CW'(dis_delay) > CW'(discharge_thr_reg))
                    && (charge_delay_reg < LIMIT) && (dis_delay < LIMIT);
                votes  = vote_count_reg + RW'(vote);
                rounds = round_count_reg + RW'(1);
                if (rounds >= RW'(ROUNDS))
                begin
                    done = 1'b1;
                    if (LIMIT_W'(votes) >= vote_limit_reg)
                    begin
                        verdict = VERDICT_TOUCHED;
                    end
                    else if (votes == '0)
                    begin
                        verdict = VERDICT_RELEASED;
                    end
                    else
                    begin
                        verdict = VERDICT_UNDECIDED;
                    end
                    round_count_next = '0;
                    vote_count_next  = '0;
                    key_next = (key_reg == LAST_KEY) ? '0 : key_reg + KEY_W'(1);
                end
                else
                begin
                    round_count_next = rounds;
                    vote_count_next  = votes;
                end
            end
        end
    end

    assign update.en      = done;
    assign update.verdict = verdict;

    tkcts_key_store #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_W    (KEY_W)
    ) u_key_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (update),
        .key        (key_reg),
        .ms_time    (ms_time_next),
        .holdoff_ms (holdoff_reg),
        .history    (history)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_thr_reg    <= CHARGE_THR_RST;
            discharge_thr_reg <= DISCHARGE_THR_RST;
            holdoff_reg       <= HOLDOFF_MS_RST;
            vote_limit_reg    <= VOTE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHARGE_THR:    charge_thr_reg    <= cfg_data[THR_W-1:0];
                CFG_DISCHARGE_THR: discharge_thr_reg <= cfg_data[THR_W-1:0];
                CFG_HOLDOFF_MS:    holdoff_reg       <= cfg_data[HOLD_W-1:0];
                CFG_VOTE_LIMIT:    vote_limit_reg    <= cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discharging_reg  <= 1'b0;
            delay_count_reg  <= '0;
            charge_delay_reg <= '0;
            round_count_reg  <= '0;
            vote_count_reg   <= '0;
            key_reg          <= '0;
            ms_time_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            discharging_reg  <= discharging_next;
            delay_count_reg  <= delay_count_next;
            charge_delay_reg <= charge_delay_next;
            round_count_reg  <= round_count_next;
            vote_count_reg   <= vote_count_next;
            key_reg          <= key_next;
            ms_time_reg      <= ms_time_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.drive_level <= !discharging_next;
            out_data_reg.key_index   <= 2'(key_reg);
            out_data_reg.key_done    <= done;
            out_data_reg.verdict     <= verdict;
            out_data_reg.key_history <= history;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/tkcts_key_store.sv]
module tkcts_key_store
    import tkcts_pkg::*;
#(
    parameter int NUM_KEYS = 4,
    parameter int KEY_W    = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_update_t       update,
    input  logic [KEY_W-1:0]  key,
    input  logic [TIME_W-1:0] ms_time,
    input  logic [HOLD_W-1:0] holdoff_ms,
    output logic [HIST_W-1:0] history
);

    logic [HIST_W-1:0] history_reg [NUM_KEYS];
    logic [TIME_W-1:0] touch_time_reg [NUM_KEYS];
    logic [HIST_W-1:0] history_next;
    logic [TIME_W-1:0] elapsed;
    logic              stamp;

    always_comb
    begin
        elapsed      = ms_time - touch_time_reg[key];
        history_next = history_reg[key];
        stamp        = 1'b0;
        if (update.en)
        begin
            case (update.verdict)
                VERDICT_TOUCHED:
                begin
                    history_next = {history_reg[key][HIST_W-2:0], 1'b1};
                    stamp        = 1'b1;
                end
                VERDICT_RELEASED:
                begin
                    // a release only counts once the hold-off has run out
                    if (elapsed > holdoff_ms)
                    begin
                        history_next = {history_reg[key][HIST_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    history_next = history_reg[key];
                end
            endcase
        end
    end

    assign history = history_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                history_reg[i]    <= '0;
                touch_time_reg[i] <= '0;
            end
        end
        else if (update.en)
        begin
            history_reg[key] <= history_next;
            if (stamp)
            begin
                touch_time_reg[key] <= ms_time;
            end
        end
    end

endmodule

[rtl/tkcts_checker.sv]
`include "touch_key_charge_time_sensor_unit_defines.svh"

module tkcts_checker
    import tkcts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // a held result must not move
    `TKCTS_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")

    // input only backs up behind a stalled, full output register
    `TKCTS_IMPLIES(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

    `TKCTS_IMPLIES(a_verdict_idle, out_valid && !out_data.key_done, out_data.verdict == VERDICT_RELEASED, "verdict set without key done")

    `TKCTS_IMPLIES(a_touch_hist, out_valid && out_data.key_done && out_data.verdict == VERDICT_TOUCHED, out_data.key_history[0], "touched without history bit")

    // an accepted request always shows up as a result on the next edge
    `TKCTS_ASSERT(a_accept_result, (in_valid && !in_stall) |=> out_valid, "accepted request produced no result")

endmodule

bind touch_key_charge_time_sensor_unit tkcts_checker u_tkcts_checker (.*);
